@@ hdl/time_window_extremum_tracker_macros.svh @@
// ----------------------------------------------------------------------------
// time_window_extremum_tracker_macros
// Assertion macros used by the tracker top level.
// ----------------------------------------------------------------------------
`ifndef TIME_WINDOW_EXTREMUM_TRACKER_MACROS_SVH
`define TIME_WINDOW_EXTREMUM_TRACKER_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define TWET_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define TWET_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/twet_pkg.sv @@
// ----------------------------------------------------------------------------
// twet_pkg
// Shared widths, register codes and cell-to-cell types of the time window
// extremum tracker.
// ----------------------------------------------------------------------------
package twet_pkg;

  localparam int TWET_DEPTH  = 64;
  localparam int TIME_W      = 32;
  localparam int VALUE_W     = 32;
  localparam int COUNT_W     = 7;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [TIME_W-1:0] WIDTH_RESET = TIME_W'(1000);

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WINDOW_WIDTH = 2'd0,
    REG_EXTREME_MODE = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    MODE_MAX = 1'b0,
    MODE_MIN = 1'b1
  } mode_t;

  // one held sample, as it moves from a cell to its older neighbor
  typedef struct packed {
    logic                      valid;
    logic [TIME_W-1:0]         stamp;
    logic signed [VALUE_W-1:0] val;
    logic                      dom_max;  // a newer held sample is >= this one
    logic                      dom_min;  // a newer held sample is <= this one
  } twet_entry_t;

  // control and data broadcast to every cell
  typedef struct packed {
    logic                      update;
    logic                      start;
    logic [TIME_W-1:0]         now;
    logic signed [VALUE_W-1:0] new_value;
    logic [TIME_W-1:0]         width;
    mode_t                     mode;
  } twet_bcast_t;

endpackage

@@ hdl/twet_in_if.sv @@
// ----------------------------------------------------------------------------
// twet_in_if
// Sample channel: valid/ready handshake with time, value and series start.
// ----------------------------------------------------------------------------
interface twet_in_if
  import twet_pkg::*;
();

  logic                      valid;
  logic                      ready;
  logic [TIME_W-1:0]         sample_time;
  logic signed [VALUE_W-1:0] sample_value;
  logic                      series_start;

  modport source (output valid, output sample_time, output sample_value,
                  output series_start, input ready);
  modport sink   (input valid, input sample_time, input sample_value,
                  input series_start, output ready);

endinterface

@@ hdl/twet_out_if.sv @@
// ----------------------------------------------------------------------------
// twet_out_if
// Result channel: valid/ready handshake with extreme, count and overflow.
// ----------------------------------------------------------------------------
interface twet_out_if
  import twet_pkg::*;
();

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] window_extreme;
  logic [COUNT_W-1:0]        window_count;
  logic                      window_overflow;

  modport source (output valid, output window_extreme, output window_count,
                  output window_overflow, input ready);
  modport sink   (input valid, input window_extreme, input window_count,
                  input window_overflow, output ready);

endinterface

@@ hdl/twet_cfg_if.sv @@
// ----------------------------------------------------------------------------
// twet_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface twet_cfg_if
  import twet_pkg::*;
();

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] reg_index;
  logic [CFG_DATA_W-1:0]  reg_data;

  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink   (input valid, input reg_index, input reg_data, output ready);

endinterface

@@ hdl/twet_cell.sv @@
// ----------------------------------------------------------------------------
// twet_cell
// One slot of the sample chain. Decides its own expiry from the older
// neighbor's status, hands its sample to the older neighbor on update and
// takes the newer neighbor's, and marks itself as the window extreme.
// ----------------------------------------------------------------------------
module twet_cell
  import twet_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  twet_bcast_t               bc,
  input  twet_entry_t               entry_in,    // from the newer neighbor
  output twet_entry_t               entry_out,   // to the older neighbor
  input  logic                      gone_older,  // every older cell is empty or expires
  output logic                      gone,
  input  logic                      cand_older,  // an older cell is a candidate
  output logic                      cand_chain,
  input  logic                      held_older,
  output logic                      held,
  output logic                      head,
  output logic                      last,
  output logic signed [VALUE_W-1:0] pick
);

  logic [TIME_W-1:0]         stamp;
  logic signed [VALUE_W-1:0] val;
  logic                      dom_max;
  logic                      dom_min;
  logic                      live;
  logic                      expired;
  logic                      cand;

  // expiry: stamp + width <= now, formed at one extra bit
  assign live    = held & ~bc.start;
  assign expired = ({1'b0, stamp} + {1'b0, bc.width}) <= {1'b0, bc.now};
  assign gone    = ~live | (expired & gone_older);

  // surviving sample moves one cell older, dominance updated by the new value
  always_comb begin
    entry_out.valid   = ~gone;
    entry_out.stamp   = stamp;
    entry_out.val     = val;
    entry_out.dom_max = dom_max | (bc.new_value >= val);
    entry_out.dom_min = dom_min | (bc.new_value <= val);
  end

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (bc.update) begin
      held <= entry_in.valid;
    end
  end

  // sample payload
  always_ff @(posedge clk) begin
    if (bc.update) begin
      stamp   <= entry_in.stamp;
      val     <= entry_in.val;
      dom_max <= entry_in.dom_max;
      dom_min <= entry_in.dom_min;
    end
  end

  // the oldest undominated sample is the extreme
  assign cand       = held & ~((bc.mode == MODE_MIN) ? dom_min : dom_max);
  assign cand_chain = cand | cand_older;
  assign head       = cand & ~cand_older;
  assign pick       = head ? val : '0;

  // newest-to-oldest occupancy is contiguous, so the last held cell gives the count
  assign last = held & ~held_older;

endmodule

@@ hdl/time_window_extremum_tracker.sv @@
// A transferred sample passes the holding register, the cell chain update and
// the result register in turn. The holding register frees only at the cell
// update, so no new sample is taken while one still waits in it.
// A waiting result does not block the next two samples; a third is held off.
// Reset: synchronous, empties the window, width 1000 ticks, maximum mode.
// No clearing pass: cells empty at once on reset.
// ----------------------------------------------------------------------------
// time_window_extremum_tracker
// Sliding time-window maximum/minimum over timestamped samples, kept in a
// chain of cells ordered newest to oldest, with an overflow flag when the
// oldest unexpired sample is pushed out of the chain.
// ----------------------------------------------------------------------------
`include "time_window_extremum_tracker_macros.svh"

module time_window_extremum_tracker
  import twet_pkg::*;
#(
  parameter int WINDOW_DEPTH = TWET_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  twet_in_if.sink  sample_in,
  twet_out_if.source result_out,
  twet_cfg_if.sink cfg
);

  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

  logic [TIME_W-1:0]         width_q;
  mode_t                     mode_q;
  logic                      s1;
  logic                      s2;
  logic                      ovf_q;
  logic [TIME_W-1:0]         t_q;
  logic signed [VALUE_W-1:0] v_q;
  logic                      start_q;
  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_extreme;
  logic [COUNT_W-1:0]        out_count;
  logic                      out_ovf;

  logic                      accept;
  logic                      upd;
  logic                      sel_fire;
  twet_bcast_t               bc;
  twet_entry_t               new_entry;
  twet_entry_t               ent_out [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0]   gone_vec;
  logic [WINDOW_DEPTH-1:0]   cand_vec;
  logic [WINDOW_DEPTH-1:0]   held_vec;
  logic [WINDOW_DEPTH-1:0]   head_vec;
  logic [WINDOW_DEPTH-1:0]   last_vec;
  logic signed [VALUE_W-1:0] pick_arr [WINDOW_DEPTH];
  logic signed [VALUE_W-1:0] ext_or;
  logic [CNT_W-1:0]          cnt_or;

  // configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_q <= WIDTH_RESET;
      mode_q  <= MODE_MAX;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.reg_index))
        REG_WINDOW_WIDTH: width_q <= cfg.reg_data[TIME_W-1:0];
        REG_EXTREME_MODE: mode_q  <= mode_t'(cfg.reg_data[0]);
        default: ;
      endcase
    end
  end

  // handshake and stage control
  assign sample_in.ready = ~s1;
  assign accept          = sample_in.valid & ~s1;
  assign sel_fire        = s2 & (~out_valid | result_out.ready);
  assign upd             = s1 & (~s2 | sel_fire);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1        <= 1'b0;
      s2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1 <= 1'b1;
      end else if (upd) begin
        s1 <= 1'b0;
      end
      if (upd) begin
        s2 <= 1'b1;
      end else if (sel_fire) begin
        s2 <= 1'b0;
      end
      if (sel_fire) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // sample holding register
  always_ff @(posedge clk) begin
    if (accept) begin
      t_q     <= sample_in.sample_time;
      v_q     <= sample_in.sample_value;
      start_q <= sample_in.series_start;
    end
  end

  // broadcast to the cells and the new sample entering the newest cell
  always_comb begin
    bc.update    = upd;
    bc.start     = start_q;
    bc.now       = t_q;
    bc.new_value = v_q;
    bc.width     = width_q;
    bc.mode      = mode_q;
    new_entry.valid   = 1'b1;
    new_entry.stamp   = t_q;
    new_entry.val     = v_q;
    new_entry.dom_max = 1'b0;
    new_entry.dom_min = 1'b0;
  end

  // cell chain, cell 0 newest
  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    twet_entry_t entry_in;
    logic        gone_older;
    logic        cand_older;
    logic        held_older;

    if (i == 0) begin : g_first
      assign entry_in = new_entry;
    end else begin : g_inner
      assign entry_in = ent_out[i-1];
    end

    if (i == WINDOW_DEPTH - 1) begin : g_oldest
      assign gone_older = 1'b1;
      assign cand_older = 1'b0;
      assign held_older = 1'b0;
    end else begin : g_younger
      assign gone_older = gone_vec[i+1];
      assign cand_older = cand_vec[i+1];
      assign held_older = held_vec[i+1];
    end

    twet_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .bc         (bc),
      .entry_in   (entry_in),
      .entry_out  (ent_out[i]),
      .gone_older (gone_older),
      .gone       (gone_vec[i]),
      .cand_older (cand_older),
      .cand_chain (cand_vec[i]),
      .held_older (held_older),
      .held       (held_vec[i]),
      .head       (head_vec[i]),
      .last       (last_vec[i]),
      .pick       (pick_arr[i])
    );
  end

  // overflow: the oldest cell still held an unexpired sample when shifted out
  always_ff @(posedge clk) begin
    if (upd) begin
      ovf_q <= ent_out[WINDOW_DEPTH-1].valid;
    end
  end

  // extreme and count from the one-hot head and last markers
  always_comb begin
    ext_or = '0;
    cnt_or = '0;
    for (int k = 0; k < WINDOW_DEPTH; k++) begin
      ext_or = ext_or | pick_arr[k];
      if (last_vec[k]) begin
        cnt_or = cnt_or | CNT_W'(k + 1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (sel_fire) begin
      out_extreme <= ext_or;
      out_count   <= COUNT_W'(cnt_or);
      out_ovf     <= ovf_q;
    end
  end

  assign result_out.valid           = out_valid;
  assign result_out.window_extreme  = out_extreme;
  assign result_out.window_count    = out_count;
  assign result_out.window_overflow = out_ovf;

  // checks
  `TWET_ASSERT_NOW(a_held_contiguous, 1'b1, ((held_vec >> 1) & ~held_vec) == '0, "held cells not contiguous")
  `TWET_ASSERT_NOW(a_head_onehot, s2, $onehot(head_vec), "extreme head not one-hot")
  `TWET_ASSERT_NOW(a_overflow_full, s2 && ovf_q, &held_vec, "overflow without a full chain")
  `TWET_ASSERT_NEXT(a_newest_held, upd, held_vec[0], "newest cell empty after update")

endmodule
